// File: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shorthand for clocked implication checks used across the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/svke_pkg.sv
// ============================================================================
// svke_pkg
// Formats, fixed constants, reset values and shared types of the shaft
// velocity estimator.
// ============================================================================
package svke_pkg;

    // Fixed point formats
    localparam int SIGNAL_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS   = 30;
    localparam int GAIN_FRAC_BITS   = 16;
    localparam int GAIN_W           = GAIN_FRAC_BITS + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

    // Low-pass pole 0.969 and zero 0.0155, rounded to the coefficient format
    localparam logic [63:0] LP_POLE_W = ((64'd969 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] LP_ZERO_W = ((64'd155 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [32:0] LP_POLE   = LP_POLE_W[32:0];
    localparam logic [32:0] LP_ZERO   = LP_ZERO_W[32:0];

    // Register reset values
    localparam logic [63:0] RST_Q_W  = ((64'd1 << SIGNAL_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] RST_R_W  = ((64'd401 << SIGNAL_FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] RST_B0_W =
        ((64'd1875 << COEF_FRAC_BITS) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] RST_F1_MAG = ((64'd1888 << COEF_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] RST_F2_W = ((64'd8905 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;

    localparam logic [31:0] RST_Q  = RST_Q_W[31:0];
    localparam logic [31:0] RST_R  = RST_R_W[31:0];
    localparam logic [31:0] RST_B0 = RST_B0_W[31:0];
    localparam logic [31:0] RST_F1 = 32'(64'd0 - RST_F1_MAG);
    localparam logic [31:0] RST_F2 = RST_F2_W[31:0];

    // Rounding shift applied to the accumulated sum
    typedef enum logic [1:0] {
        RND_NONE,
        RND_GAIN,
        RND_COEF
    } svke_rnd_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic      issue;
        logic      clear;
        svke_rnd_t rnd;
    } svke_mac_ctrl_t;

    // Status of the serial gain divider
    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quot;
    } svke_div_stat_t;

endpackage

// File: sv/svke_mac.sv
// ============================================================================
// svke_mac
// Shared signed multiply-accumulate unit with round-to-nearest shift and
// 32-bit saturation of the accumulated sum.
// ============================================================================
module svke_mac (
    input  logic                    clk,
    input  logic                    rst_n,
    input  svke_pkg::svke_mac_ctrl_t ctrl,
    input  logic signed [32:0]      op_a,
    input  logic signed [32:0]      op_b,
    output logic signed [31:0]      res_sat,
    output logic [31:0]             res_low
);

    localparam logic signed [67:0] HALF_GAIN = 68'sd1 <<< (svke_pkg::GAIN_FRAC_BITS - 1);
    localparam logic signed [67:0] HALF_COEF = 68'sd1 <<< (svke_pkg::COEF_FRAC_BITS - 1);
    localparam logic signed [67:0] SAT_MAX   = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN   = -68'sd2147483648;

    logic               vld_reg;
    logic               clr_reg;
    logic signed [65:0] prod_reg;
    logic signed [67:0] acc_reg;
    logic signed [67:0] acc_next;
    logic signed [67:0] shifted;

    // Issue flags are registered alongside the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            clr_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= ctrl.issue;
            clr_reg <= ctrl.clear;
        end
    end

    // Accumulate the registered product; the first term of a sum restarts it.
    always_comb
    begin
        acc_next = (clr_reg ? 68'sd0 : acc_reg) + $signed({{2{prod_reg[65]}}, prod_reg});
    end

    // Multiplier and accumulator registers
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= op_a * op_b;
        end
        if (vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round to nearest with ties upward, then saturate.
    always_comb
    begin
        case (ctrl.rnd)
            svke_pkg::RND_NONE: shifted = acc_reg;
            svke_pkg::RND_GAIN: shifted = (acc_reg + HALF_GAIN) >>> svke_pkg::GAIN_FRAC_BITS;
            svke_pkg::RND_COEF: shifted = (acc_reg + HALF_COEF) >>> svke_pkg::COEF_FRAC_BITS;
            default:            shifted = acc_reg;
        endcase

        if (shifted > SAT_MAX)
        begin
            res_sat = 32'sh7FFFFFFF;
        end
        else if (shifted < SAT_MIN)
        begin
            res_sat = 32'sh80000000;
        end
        else
        begin
            res_sat = shifted[31:0];
        end
        res_low = shifted[31:0];
    end

endmodule

// File: sv/svke_div.sv
// ============================================================================
// svke_div
// Serial restoring divider for the Kalman gain, one quotient bit a cycle:
// gain = round(prior * 2^16 / (prior + r_noise)), zero for a zero divisor.
// ============================================================================
`include "assert_macros.svh"

module svke_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              prior,
    input  logic [31:0]              rnoise,
    output svke_pkg::svke_div_stat_t stat
);

    localparam int GW = svke_pkg::GAIN_W;
    localparam logic [4:0] LAST_ITER = 5'(GW - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [4:0]    iter_reg;
    logic [32:0]   den_reg;
    logic [32:0]   rem_reg;
    logic [GW-1:0] low_reg;
    logic [GW-1:0] quot_reg;

    logic [32:0]   den_start;
    logic [48:0]   num_start;
    logic [33:0]   trial;
    logic [33:0]   diff;
    logic          fits;
    logic [32:0]   rem_next;

    // Divisor and rounded numerator; the upper part of the numerator is
    // already below the divisor, so only the low bits need stepping through.
    always_comb
    begin
        den_start = {1'b0, prior} + {1'b0, rnoise};
        num_start = {1'b0, prior, 16'b0} + {17'b0, den_start[32:1]};
        trial     = {rem_reg, low_reg[GW-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? diff[32:0] : trial[32:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                iter_reg <= 5'd0;
                if (den_start == 33'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den_start;
            rem_reg  <= {1'b0, num_start[48:17]};
            low_reg  <= num_start[GW-1:0];
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[GW-2:0], 1'b0};
            quot_reg <= {quot_reg[GW-2:0], fits};
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

    // A finished gain never exceeds one, and completion ends the iteration.
    `ASSERT_IMPL(a_gain_range, done_reg, quot_reg <= svke_pkg::GAIN_ONE, "gain above one")
    `ASSERT_IMPL(a_done_idle, done_reg, !busy_reg, "divider busy at completion")

endmodule

// File: sv/shaft_velocity_kalman_estimator_core.sv
// ============================================================================
// shaft_velocity_kalman_estimator_core
// Shaft velocity estimator: difference velocity, low-pass smoothing and a
// scalar Kalman filter with a second-order model prediction.
//
// A sample with shaft_found set is worked through the raw, low-pass, divide,
// update, posterior and prediction states, and its result is loaded into the
// output register before the next sample can be taken. The sequencer runs
// all products through one 33 by 33 bit multiply-accumulate unit (ten
// products). The gain comes from a serial divider that yields one quotient
// bit a cycle. When the gain denominator is zero the divider finishes at
// once. A sample with shaft_found clear gives no result and changes nothing.
// The input is ready only while the block is idle; the next sample may be
// taken while a result still waits in the output register, and its own
// result then waits until that register is free. Configuration is written
// through the APB-style port, register i at byte address 4*i; writing
// p_init reloads the variance.
// ============================================================================
`include "assert_macros.svh"

module shaft_velocity_kalman_estimator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Sample channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                shaft_position,
    input  logic                              shaft_found,
    input  logic signed [31:0]                motor_voltage,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                raw_velocity,
    output logic signed [31:0]                smoothed_velocity,
    output logic [svke_pkg::GAIN_W-1:0]       gain,
    output logic [31:0]                       prior_variance,
    output logic signed [31:0]                updated_velocity,
    output logic signed [31:0]                next_prediction
);

    localparam int GW = svke_pkg::GAIN_W;

    // Register indexes
    localparam logic [2:0] REG_Q  = 3'd0;
    localparam logic [2:0] REG_R  = 3'd1;
    localparam logic [2:0] REG_P  = 3'd2;
    localparam logic [2:0] REG_B0 = 3'd3;
    localparam logic [2:0] REG_F1 = 3'd4;
    localparam logic [2:0] REG_F2 = 3'd5;

    // Step counts at which each sum is ready in the accumulator
    localparam logic [2:0] CAP_ONE   = 3'd2;
    localparam logic [2:0] CAP_TWO   = 3'd3;
    localparam logic [2:0] CAP_THREE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAW,
        S_LP,
        S_DIV,
        S_UPD,
        S_POST,
        S_NEXT
    } state_t;

    function automatic logic signed [32:0] sx33(input logic [31:0] v);
        return $signed({v[31], v});
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    state_t       state_reg;
    logic [2:0]   cnt_reg;

    // Configuration registers
    logic [31:0]  q_reg;
    logic [31:0]  r_reg;
    logic [31:0]  pinit_reg;
    logic [31:0]  b0_reg;
    logic [31:0]  f1_reg;
    logic [31:0]  f2_reg;

    // Filter state
    logic [31:0]  last_pos_reg;
    logic [31:0]  filt_out_reg;
    logic [31:0]  filt_in_reg;
    logic [31:0]  prior_var_reg;
    logic [31:0]  pred_vel_reg;
    logic [31:0]  prev_vel_reg;

    // Working values of the sample in progress
    logic [31:0]  pos_reg;
    logic [31:0]  volt_reg;
    logic [31:0]  raw_reg;
    logic [31:0]  smooth_reg;
    logic [GW-1:0] k_reg;
    logic [31:0]  vupd_reg;
    logic [31:0]  post_reg;

    // Output register
    logic         out_valid_reg;
    logic [31:0]  out_raw_reg;
    logic [31:0]  out_smooth_reg;
    logic [GW-1:0] out_gain_reg;
    logic [31:0]  out_prior_reg;
    logic [31:0]  out_vupd_reg;
    logic [31:0]  out_vnext_reg;

    svke_pkg::svke_mac_ctrl_t mac_ctrl;
    svke_pkg::svke_div_stat_t div_stat;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [31:0] mac_sat;
    logic [31:0]        mac_low;
    logic               div_start;

    logic         cfg_wr;
    logic         in_xfer;
    logic         raw_cap;
    logic         lp_cap;
    logic         div_cap;
    logic         upd_cap;
    logic         post_cap;
    logic         commit;

    // Shared arithmetic units
    svke_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .res_sat (mac_sat),
        .res_low (mac_low)
    );

    svke_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .prior  (prior_var_reg),
        .rnoise (r_reg),
        .stat   (div_stat)
    );

    // Handshake and capture strobes
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign raw_cap   = (state_reg == S_RAW)  && (cnt_reg == CAP_ONE);
    assign lp_cap    = (state_reg == S_LP)   && (cnt_reg == CAP_THREE);
    assign div_cap   = (state_reg == S_DIV)  && (cnt_reg != 3'd0) && div_stat.done;
    assign upd_cap   = (state_reg == S_UPD)  && (cnt_reg == CAP_TWO);
    assign post_cap  = (state_reg == S_POST) && (cnt_reg == CAP_ONE);
    assign commit    = (state_reg == S_NEXT) && (cnt_reg == CAP_THREE) &&
                       (!out_valid_reg || out_ready);
    assign div_start = (state_reg == S_DIV)  && (cnt_reg == 3'd0);

    // Operand selection for each term of each sum of products
    always_comb
    begin
        mac_ctrl.issue = 1'b0;
        mac_ctrl.clear = (cnt_reg == 3'd0);
        mac_ctrl.rnd   = svke_pkg::RND_NONE;
        op_a           = 33'sd0;
        op_b           = 33'sd0;
        case (state_reg)
            S_RAW:
            begin
                mac_ctrl.issue = (cnt_reg == 3'd0);
                op_a           = sx33(pos_reg) - sx33(last_pos_reg);
                op_b           = 33'sd100;
            end
            S_LP:
            begin
                mac_ctrl.rnd   = svke_pkg::RND_COEF;
                mac_ctrl.issue = (cnt_reg < 3'd3);
                case (cnt_reg)
                    3'd0:
                    begin
                        op_a = $signed(svke_pkg::LP_POLE);
                        op_b = sx33(filt_out_reg);
                    end
                    3'd1:
                    begin
                        op_a = $signed(svke_pkg::LP_ZERO);
                        op_b = sx33(raw_reg);
                    end
                    default:
                    begin
                        op_a = $signed(svke_pkg::LP_ZERO);
                        op_b = sx33(filt_in_reg);
                    end
                endcase
            end
            S_UPD:
            begin
                mac_ctrl.rnd   = svke_pkg::RND_GAIN;
                mac_ctrl.issue = (cnt_reg < 3'd2);
                if (cnt_reg == 3'd0)
                begin
                    op_a = $signed({16'b0, k_reg});
                    op_b = sx33(raw_reg) - sx33(pred_vel_reg);
                end
                else
                begin
                    // The prediction enters at the gain scale so one rounding covers both.
                    op_a = sx33(pred_vel_reg);
                    op_b = $signed({16'b0, svke_pkg::GAIN_ONE});
                end
            end
            S_POST:
            begin
                mac_ctrl.rnd   = svke_pkg::RND_GAIN;
                mac_ctrl.issue = (cnt_reg == 3'd0);
                op_a           = $signed({16'b0, svke_pkg::GAIN_ONE} - {16'b0, k_reg});
                op_b           = $signed({1'b0, prior_var_reg});
            end
            S_NEXT:
            begin
                mac_ctrl.rnd   = svke_pkg::RND_COEF;
                mac_ctrl.issue = (cnt_reg < 3'd3);
                case (cnt_reg)
                    3'd0:
                    begin
                        op_a = sx33(b0_reg);
                        op_b = sx33(volt_reg);
                    end
                    3'd1:
                    begin
                        op_a = 33'sd0 - sx33(f1_reg);
                        op_b = sx33(vupd_reg);
                    end
                    default:
                    begin
                        op_a = 33'sd0 - sx33(f2_reg);
                        op_b = sx33(prev_vel_reg);
                    end
                endcase
            end
            default:
            begin
                mac_ctrl.issue = 1'b0;
            end
        endcase
    end

    // Register read-back
    always_comb
    begin
        case (paddr[4:2])
            REG_Q:   prdata = q_reg;
            REG_R:   prdata = r_reg;
            REG_P:   prdata = pinit_reg;
            REG_B0:  prdata = b0_reg;
            REG_F1:  prdata = f1_reg;
            REG_F2:  prdata = f2_reg;
            default: prdata = 32'd0;
        endcase
    end

    // Sequencer, configuration, filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= 3'd0;
            q_reg          <= svke_pkg::RST_Q;
            r_reg          <= svke_pkg::RST_R;
            pinit_reg      <= 32'd0;
            b0_reg         <= svke_pkg::RST_B0;
            f1_reg         <= svke_pkg::RST_F1;
            f2_reg         <= svke_pkg::RST_F2;
            last_pos_reg   <= 32'd0;
            filt_out_reg   <= 32'd0;
            filt_in_reg    <= 32'd0;
            prior_var_reg  <= svke_pkg::RST_Q;
            pred_vel_reg   <= 32'd0;
            prev_vel_reg   <= 32'd0;
            out_valid_reg  <= 1'b0;
            out_raw_reg    <= 32'd0;
            out_smooth_reg <= 32'd0;
            out_gain_reg   <= '0;
            out_prior_reg  <= 32'd0;
            out_vupd_reg   <= 32'd0;
            out_vnext_reg  <= 32'd0;
        end
        else
        begin
            // Configuration writes are for the user to make only while idle; the block itself does not enforce this.
            if (cfg_wr)
            begin
                case (paddr[4:2])
                    REG_Q:  q_reg  <= pwdata;
                    REG_R:  r_reg  <= pwdata;
                    REG_P:
                    begin
                        pinit_reg     <= pwdata;
                        prior_var_reg <= add_sat(pwdata, q_reg);
                    end
                    REG_B0: b0_reg <= pwdata;
                    REG_F1: f1_reg <= pwdata;
                    REG_F2: f2_reg <= pwdata;
                    default: ;
                endcase
            end

            // A taken result empties the output register unless a new one
            // replaces it in the same cycle.
            if (out_valid_reg && out_ready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= 3'd0;
                    if (in_xfer && shaft_found)
                    begin
                        state_reg <= S_RAW;
                    end
                end
                S_RAW:
                begin
                    if (raw_cap)
                    begin
                        state_reg <= S_LP;
                        cnt_reg   <= 3'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_LP:
                begin
                    if (lp_cap)
                    begin
                        state_reg <= S_DIV;
                        cnt_reg   <= 3'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_DIV:
                begin
                    if (div_cap)
                    begin
                        state_reg <= S_UPD;
                        cnt_reg   <= 3'd0;
                    end
                    else
                    begin
                        cnt_reg <= 3'd1;
                    end
                end
                S_UPD:
                begin
                    if (upd_cap)
                    begin
                        state_reg <= S_POST;
                        cnt_reg   <= 3'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_POST:
                begin
                    if (post_cap)
                    begin
                        state_reg <= S_NEXT;
                        cnt_reg   <= 3'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_NEXT:
                begin
                    // Hold the finished sum until the output register is free.
                    if (commit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_raw_reg    <= raw_reg;
                        out_smooth_reg <= smooth_reg;
                        out_gain_reg   <= k_reg;
                        out_prior_reg  <= prior_var_reg;
                        out_vupd_reg   <= vupd_reg;
                        out_vnext_reg  <= mac_sat;
                        last_pos_reg   <= pos_reg;
                        filt_in_reg    <= raw_reg;
                        filt_out_reg   <= smooth_reg;
                        prior_var_reg  <= add_sat(post_reg, q_reg);
                        prev_vel_reg   <= vupd_reg;
                        pred_vel_reg   <= mac_sat;
                        state_reg      <= S_IDLE;
                        cnt_reg        <= 3'd0;
                    end
                    else if (cnt_reg != CAP_THREE)
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    cnt_reg   <= 3'd0;
                end
            endcase
        end
    end

    // Working values of the sample in progress
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pos_reg  <= shaft_position;
            volt_reg <= motor_voltage;
        end
        if (raw_cap)
        begin
            raw_reg <= mac_sat;
        end
        if (lp_cap)
        begin
            smooth_reg <= mac_sat;
        end
        if (div_cap)
        begin
            k_reg <= div_stat.quot;
        end
        if (upd_cap)
        begin
            vupd_reg <= mac_sat;
        end
        if (post_cap)
        begin
            post_reg <= mac_low;
        end
    end

    assign out_valid         = out_valid_reg;
    assign raw_velocity      = out_raw_reg;
    assign smoothed_velocity = out_smooth_reg;
    assign gain              = out_gain_reg;
    assign prior_variance    = out_prior_reg;
    assign updated_velocity  = out_vupd_reg;
    assign next_prediction   = out_vnext_reg;

    // A valid sample occupies the block, and a new result appears only as
    // the sequencer returns to idle.
    `ASSERT_NEXT(a_busy_after_sample, in_xfer && shaft_found, !in_ready, "ready while busy")
    `ASSERT_IMPL(a_result_at_idle, $rose(out_valid_reg), state_reg == S_IDLE, "result not at idle")

endmodule

// File: dv/shaft_velocity_kalman_estimator_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// shaft_velocity_kalman_estimator_core_test
// Self-checking bench for the shaft velocity estimator. Samples are driven
// through the valid/ready input channel and every result transfer is
// compared field by field with a cycle-free model of the difference
// velocity, the low-pass stage, the scalar Kalman update and the model
// prediction. A directed opening covers saturation, skipped samples, a zero
// gain denominator and variance overflow; random phases with fresh register
// settings, idle gaps on both sides and one long output stall follow.
// ============================================================================
module shaft_velocity_kalman_estimator_core_test;

    // Register map seen through the configuration port
    typedef enum int {
        REG_Q_NOISE    = 0,
        REG_R_NOISE    = 1,
        REG_P_INIT     = 2,
        REG_BJ_B0      = 3,
        REG_BJ_F1      = 4,
        REG_BJ_F2      = 5,
        REG_UNMAPPED_0 = 6,
        REG_UNMAPPED_1 = 7
    } reg_index_t;

    localparam int     NUM_REGS       = 6;
    localparam int     DRAIN_CYCLES   = 60;
    localparam int     STALL_LIMIT    = 5000;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_SAMPLES  = 152;
    localparam int     HOLD_AFTER     = 500;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint S32_MAX        = 64'sd2147483647;
    localparam longint S32_MIN        = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] position;
        logic               found;
        logic signed [31:0] voltage;
    } shaft_sample_t;

    typedef struct {
        logic signed [31:0]             raw;
        logic signed [31:0]             smooth;
        logic [svke_pkg::GAIN_W-1:0]    k;
        logic [31:0]                    prior;
        logic signed [31:0]             vupd;
        logic signed [31:0]             vnext;
    } velocity_result_t;

    // Clock, reset and block ports
    logic                        clk               = 1'b0;
    logic                        rst_n             = 1'b0;
    logic                        psel              = 1'b0;
    logic                        penable           = 1'b0;
    logic                        pwrite            = 1'b0;
    logic [4:0]                  paddr             = '0;
    logic [31:0]                 pwdata            = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid          = 1'b0;
    logic                        in_ready;
    logic signed [31:0]          shaft_position    = '0;
    logic                        shaft_found       = 1'b0;
    logic signed [31:0]          motor_voltage     = '0;
    logic                        out_valid;
    logic                        out_ready         = 1'b0;
    logic signed [31:0]          raw_velocity;
    logic signed [31:0]          smoothed_velocity;
    logic [svke_pkg::GAIN_W-1:0] gain;
    logic [31:0]                 prior_variance;
    logic signed [31:0]          updated_velocity;
    logic signed [31:0]          next_prediction;

    // Bench bookkeeping
    shaft_sample_t    pending_samples[$];
    velocity_result_t expected_results[$];
    logic             in_taken      = 1'b0;
    logic             out_taken     = 1'b0;
    logic             hold_off      = 1'b0;
    logic             no_idle       = 1'b0;
    int               in_gap        = 0;
    int               out_wait      = 0;
    int               results_seen  = 0;
    int               stall_cycles  = 0;
    int               error_count   = 0;

    // Estimator copy: settings and state
    logic [31:0]        q_noise_m, r_noise_m, p_init_m, prior_var_m;
    logic signed [31:0] b0_m, f1_m, f2_m;
    logic signed [31:0] last_pos_m, lp_out_m, lp_in_m, pred_vel_m, prev_vel_m;

    shaft_velocity_kalman_estimator_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .shaft_position    (shaft_position),
        .shaft_found       (shaft_found),
        .motor_voltage     (motor_voltage),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .raw_velocity      (raw_velocity),
        .smoothed_velocity (smoothed_velocity),
        .gain              (gain),
        .prior_variance    (prior_variance),
        .updated_velocity  (updated_velocity),
        .next_prediction   (next_prediction)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Saturation to the signed 32-bit range.
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > S32_MAX)
            return 32'sh7FFFFFFF;
        if (v < S32_MIN)
            return 32'sh80000000;
        return 32'(v);
    endfunction

    function automatic logic [31:0] add_sat_u32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    // Exact sum of three coefficient products, rounded to nearest with ties up.
    function automatic longint round_coef(input longint a, input longint b, input longint c);
        logic signed [127:0] acc;
        acc = a;
        acc = acc + b + c + (128'sd1 <<< (svke_pkg::COEF_FRAC_BITS - 1));
        return longint'(acc >>> svke_pkg::COEF_FRAC_BITS);
    endfunction

    function automatic void reset_estimator();
        q_noise_m   = svke_pkg::RST_Q;
        r_noise_m   = svke_pkg::RST_R;
        p_init_m    = '0;
        b0_m        = signed'(svke_pkg::RST_B0);
        f1_m        = signed'(svke_pkg::RST_F1);
        f2_m        = signed'(svke_pkg::RST_F2);
        last_pos_m  = '0;
        lp_out_m    = '0;
        lp_in_m     = '0;
        pred_vel_m  = '0;
        prev_vel_m  = '0;
        prior_var_m = add_sat_u32('0, svke_pkg::RST_Q);
    endfunction

    function automatic void apply_register(input reg_index_t idx, input logic [31:0] value);
        case (idx)
            REG_Q_NOISE: q_noise_m = value;
            REG_R_NOISE: r_noise_m = value;
            REG_P_INIT:
            begin
                // Writing the initial variance also reloads the running variance.
                p_init_m    = value;
                prior_var_m = add_sat_u32(value, q_noise_m);
            end
            REG_BJ_B0:   b0_m = signed'(value);
            REG_BJ_F1:   f1_m = signed'(value);
            REG_BJ_F2:   f2_m = signed'(value);
            default:     ;
        endcase
    endfunction

    // Works out the result of one present sample and advances the state.
    function automatic void estimate_sample(input logic signed [31:0] pos,
                                            input logic signed [31:0] volt);
        velocity_result_t r;
        longint           raw_v;
        logic [63:0]      den, k_v, post_v;
        r.prior = prior_var_m;
        r.raw   = clamp32((longint'(pos) - longint'(last_pos_m)) * 100);
        raw_v   = longint'(r.raw);
        r.smooth = clamp32(round_coef(longint'(svke_pkg::LP_POLE) * longint'(lp_out_m),
                                      longint'(svke_pkg::LP_ZERO) * raw_v,
                                      longint'(svke_pkg::LP_ZERO) * longint'(lp_in_m)));
        // Gain with a zero denominator is forced to zero.
        den = 64'(r.prior) + 64'(r_noise_m);
        if (den == 0)
            k_v = '0;
        else
            k_v = ((64'(r.prior) << svke_pkg::GAIN_FRAC_BITS) + (den >> 1)) / den;
        r.k = k_v[svke_pkg::GAIN_W-1:0];
        r.vupd = clamp32(longint'(pred_vel_m) +
                         ((longint'(k_v) * (raw_v - longint'(pred_vel_m)) +
                           (longint'(svke_pkg::GAIN_ONE) >>> 1)) >>> svke_pkg::GAIN_FRAC_BITS));
        post_v = ((64'(svke_pkg::GAIN_ONE) - k_v) * 64'(r.prior) +
                  64'(svke_pkg::GAIN_ONE >> 1)) >> svke_pkg::GAIN_FRAC_BITS;
        r.vnext = clamp32(round_coef(longint'(b0_m) * longint'(volt),
                                     -longint'(f1_m) * longint'(r.vupd),
                                     -longint'(f2_m) * longint'(prev_vel_m)));
        last_pos_m  = pos;
        lp_in_m     = r.raw;
        lp_out_m    = r.smooth;
        prior_var_m = add_sat_u32(post_v[31:0], q_noise_m);
        prev_vel_m  = r.vupd;
        pred_vel_m  = r.vnext;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic int draw_idle();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void queue_sample(input logic signed [31:0] pos, input logic found,
                                         input logic signed [31:0] volt);
        shaft_sample_t s;
        s.position = pos;
        s.found    = found;
        s.voltage  = volt;
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // Sample driver: holds each sample until its transfer, then idles a drawn gap.
    always @(negedge clk)
    begin : drive_samples
        shaft_sample_t s;
        if (in_valid && !in_taken)
        begin
            // Sample still waiting for its transfer.
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap = in_gap - 1;
        end
        else if (pending_samples.size() != 0)
        begin
            s = pending_samples.pop_front();
            shaft_position <= s.position;
            shaft_found    <= s.found;
            motor_voltage  <= s.voltage;
            in_valid       <= 1'b1;
            in_gap = draw_idle();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result receiver: stalls a drawn number of cycles after each transfer.
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (out_taken)
        begin
            out_wait = draw_idle();
            out_ready <= (out_wait == 0);
            if (out_wait != 0)
                out_wait = out_wait - 1;
        end
        else if (out_wait > 0)
        begin
            out_ready <= 1'b0;
            out_wait = out_wait - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // One long output stall in the middle of a random phase, so that the
    // block fills up and has to refuse input.
    initial
    begin
        wait (results_seen >= HOLD_AFTER);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: predicts on each sample transfer, checks each result transfer,
    // and watches for a stalled run.
    always @(posedge clk)
    begin : watch_ports
        velocity_result_t want;
        if (rst_n)
        begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (in_valid && in_ready && shaft_found)
                estimate_sample(shaft_position, motor_voltage);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no sample pending");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("raw_velocity", want.raw, raw_velocity);
                    check_field("smoothed_velocity", want.smooth, smoothed_velocity);
                    check_field("gain", longint'(want.k), longint'(gain));
                    check_field("prior_variance", longint'(want.prior), longint'(prior_variance));
                    check_field("updated_velocity", want.vupd, updated_velocity);
                    check_field("next_prediction", want.vnext, next_prediction);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Register write followed by a read-back of mapped registers.
    task automatic program_register(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_register(idx, value);
        @(negedge clk);
        if (idx <= REG_BJ_F2)
        begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            check_field("prdata", longint'(value), longint'(prdata));
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every sample is sent and every result has come back.
    task automatic wait_for_drain();
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // New register settings: nominal, fully random or extreme values, written
    // in a rotated order so that the variance reload sees either noise value.
    task automatic reprogram(input int mode);
        int          start;
        int          j;
        reg_index_t  idx;
        logic [31:0] value;
        logic [31:0] corners[5];
        corners = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
        start = $urandom_range(0, NUM_REGS - 1);
        for (j = 0; j < NUM_REGS; j++)
        begin
            idx = reg_index_t'((start + j) % NUM_REGS);
            if (mode == 1)
                value = $urandom;
            else if (mode == 2)
                value = corners[$urandom_range(0, 4)];
            else
            begin
                case (idx)
                    REG_Q_NOISE: value = svke_pkg::RST_Q + $urandom_range(0, 256);
                    REG_R_NOISE: value = $urandom_range(1 << 10, 1 << 20);
                    REG_P_INIT:  value = $urandom_range(0, 1 << 20);
                    REG_BJ_B0:
                        value = svke_pkg::RST_B0 + $urandom_range(0, 1 << 20) - (1 << 19);
                    REG_BJ_F1:
                        value = svke_pkg::RST_F1 + $urandom_range(0, 1 << 16) - (1 << 15);
                    default:
                        value = svke_pkg::RST_F2 + $urandom_range(0, 1 << 16) - (1 << 15);
                endcase
            end
            if (mode == 2 || $urandom_range(0, 3) != 0)
                program_register(idx, value);
        end
    endtask

    // Stimulus sequence
    initial
    begin
        logic signed [31:0] track_pos;
        logic signed [31:0] pos;
        logic signed [31:0] volt;
        logic               found;
        int                 present;
        int                 kind;
        int                 span;
        int                 mode;

        reset_estimator();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: field extremes, saturated difference velocity and
        // skipped samples that must leave the state untouched.
        queue_sample(32'sh7FFFFFFF, 1'b0, 32'sh80000000);
        queue_sample(32'sh0, 1'b1, 32'sh0);
        queue_sample(32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF);
        queue_sample(32'sh80000000, 1'b1, 32'sh80000000);
        queue_sample(32'sh0, 1'b0, 32'sh0);
        queue_sample(-32'sd1, 1'b1, -32'sd1);
        queue_sample(32'sd1, 1'b1, 32'sd1);
        queue_sample(32'sd655, 1'b1, 32'sd12 <<< 16);
        queue_sample(32'sd1310, 1'b1, 32'sd12 <<< 16);
        queue_sample(32'sd1966, 1'b1, -(32'sd12 <<< 16));
        wait_for_drain();

        // Zero noise and zero initial variance: the gain denominator is zero.
        program_register(REG_Q_NOISE, 32'h0);
        program_register(REG_R_NOISE, 32'h0);
        program_register(REG_P_INIT, 32'h0);
        queue_sample(32'sd2000, 1'b1, 32'sd1 <<< 16);
        queue_sample(32'sd1000, 1'b1, 32'sd0);
        queue_sample(32'sd7, 1'b0, 32'sd9);
        queue_sample(-32'sd5000, 1'b1, 32'sd3 <<< 16);
        wait_for_drain();

        // Largest variances and coefficients; the variance sum saturates.
        // Writes beyond the register map must have no effect.
        program_register(REG_Q_NOISE, 32'hFFFFFFFF);
        program_register(REG_R_NOISE, 32'hFFFFFFFF);
        program_register(REG_P_INIT, 32'hFFFFFFFF);
        program_register(REG_BJ_B0, 32'h7FFFFFFF);
        program_register(REG_BJ_F1, 32'h80000000);
        program_register(REG_BJ_F2, 32'h80000000);
        program_register(REG_UNMAPPED_0, 32'h0);
        program_register(REG_UNMAPPED_1, 32'h12345678);
        queue_sample(32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF);
        queue_sample(32'sh80000000, 1'b1, 32'sh80000000);
        queue_sample(32'sh0, 1'b1, 32'sh7FFFFFFF);
        queue_sample(32'sh12345678, 1'b1, 32'sh80000000);
        wait_for_drain();

        // Opposite coefficient extremes with a tiny measurement noise.
        program_register(REG_BJ_B0, 32'h80000000);
        program_register(REG_BJ_F1, 32'h7FFFFFFF);
        program_register(REG_BJ_F2, 32'h7FFFFFFF);
        program_register(REG_R_NOISE, 32'h1);
        program_register(REG_P_INIT, 32'h80000000);
        queue_sample(32'sh40000000, 1'b1, 32'sh40000000);
        queue_sample(32'shC0000000, 1'b1, -32'sd1);
        queue_sample(32'sh0, 1'b1, 32'sh0);
        wait_for_drain();

        // Random phases: mostly smooth shaft trajectories with random steps,
        // mixed with skipped samples and arbitrary jumps.
        track_pos = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            no_idle = (phase % 3 == 2);
            mode = (phase == 0 || phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 2);
            reprogram(mode);
            present = 0;
            while (present < PHASE_SAMPLES)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    span = 1 << $urandom_range(2, 14);
                    track_pos = track_pos + $urandom_range(0, 2 * span) - span;
                    pos   = track_pos;
                    volt  = $urandom_range(0, 48 << 16) - (24 << 16);
                    found = 1'b1;
                end
                else if (kind == 7)
                begin
                    pos   = $urandom;
                    volt  = $urandom;
                    found = 1'b0;
                end
                else
                begin
                    pos   = $urandom;
                    volt  = $urandom;
                    found = 1'($urandom_range(0, 1));
                    if (found)
                        track_pos = pos;
                end
                queue_sample(pos, found, volt);
                if (found)
                    present++;
            end
            wait_for_drain();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
